@@ hw/rtl/wsd_pkg.sv @@
// Shared types, codes and helpers for the WebSocket frame deframer.
// Used by the frame parser and the top level; no dependencies.
`timescale 1ns / 1ps
package wsd_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int MAX_LEN_W = 32;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

	localparam logic [3:0] PH_HDR0    = 4'd0;
	localparam logic [3:0] PH_HDR1    = 4'd1;
	localparam logic [3:0] PH_EXT     = 4'd2;
	localparam logic [3:0] PH_MASK    = 4'd3;
	localparam logic [3:0] PH_PAYLOAD = 4'd4;

	localparam logic [2:0] ST_TEXT     = 3'd0;
	localparam logic [2:0] ST_CLOSE    = 3'd1;
	localparam logic [2:0] ST_PING     = 3'd2;
	localparam logic [2:0] ST_PONG     = 3'd3;
	localparam logic [2:0] ST_BINARY   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;
	localparam logic [2:0] ST_UNMASKED = 3'd6;
	localparam logic [2:0] ST_TOOLONG  = 3'd7;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       message_end;
		logic [2:0] status;
		logic [3:0] message_opcode;
	} wsd_result_t;

	function automatic logic [2:0] classify(input logic [3:0] op);
		logic [2:0] st;
		case (op)
			OP_TEXT:   st = ST_TEXT;
			OP_BINARY: st = ST_BINARY;
			OP_CLOSE:  st = ST_CLOSE;
			OP_PING:   st = ST_PING;
			OP_PONG:   st = ST_PONG;
			default:   st = ST_UNKNOWN;
		endcase
		return st;
	endfunction

endpackage

@@ hw/rtl/wsd_if.sv @@
// Valid/ready channel interfaces of the WebSocket frame deframer.
// One carries stream bytes, the other result beats; no dependencies.
`timescale 1ns / 1ps
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface wsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       message_end;
	logic [2:0] status;
	logic [3:0] message_opcode;

	modport source (output valid, output payload_byte, output payload_valid,
		output message_end, output status, output message_opcode, input ready);
	modport sink (input valid, input payload_byte, input payload_valid,
		input message_end, input status, input message_opcode, output ready);
endinterface

@@ hw/rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_if (wsd_byte_if, wsd_result_if) and wsd_parser.
//
// The stream channel takes one client-to-server byte per beat. The result channel
// gives a beat for every payload byte, unmasked with its frame's own key, and for
// every message end or error; header bytes give no beat unless they end a message.
// The cfg_wr_en/cfg_wr_data port writes the message length limit (reset 65536).
// A byte accepted from the stream sits in the input register until the parser takes
// it; its result is then registered and offered from the result register.
// Throughput is one byte per cycle while the receiver takes every beat: the parser state updates on each step.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; after that the stream is held off.
// Reset clears the parser to await a first header byte and empties both registers.
// After any status other than text the block swallows all bytes until reset.
`timescale 1ns / 1ps
module websocket_frame_deframer import wsd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [MAX_LEN_W-1:0] cfg_wr_data,
	wsd_byte_if.sink             stream,
	wsd_result_if.source         result
);

	logic                 s1_valid_q;
	logic [7:0]           data_s1;
	logic                 out_valid_q;
	wsd_result_t          out_q;
	logic [MAX_LEN_W-1:0] max_len_q;
	logic                 advance;
	logic                 res_valid;
	wsd_result_t          res;

	assign advance = s1_valid_q && (!out_valid_q || result.ready);
	assign stream.ready = !s1_valid_q || advance;

	wsd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			max_len_q   <= MAX_LEN_RESET;
		end else begin
			if (stream.valid && stream.ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
		end
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.payload_byte   = out_q.payload_byte;
	assign result.payload_valid  = out_q.payload_valid;
	assign result.message_end    = out_q.message_end;
	assign result.status         = out_q.status;
	assign result.message_opcode = out_q.message_opcode;

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!s1_valid_q || !out_valid_q) |-> stream.ready)
		else $error("stream held off with a free register");
	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.payload_valid) |-> (result.payload_byte == 8'd0))
		else $error("payload byte set on a beat without payload");
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.message_end) |-> (result.status == ST_TEXT))
		else $error("status given before message end");
	a_error_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ST_UNMASKED || result.status == ST_TOOLONG))
		|-> (result.message_end && !result.payload_valid))
		else $error("error beat carries payload");

endmodule

@@ hw/rtl/wsd_parser.sv @@
// Frame parser state and next-state logic: headers, lengths, key, unmasking.
// Processes one byte per step strobe; depends on wsd_pkg.
`timescale 1ns / 1ps
module wsd_parser import wsd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic [MAX_LEN_W-1:0] max_len,
	output logic                 res_valid,
	output wsd_result_t          res
);

	localparam int WW = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;

	logic [3:0]             phase_q, phase_n;
	logic [3:0]             first_op_q, first_op_n;
	logic                   fin_q, fin_n;
	logic [LENGTH_BITS-1:0] ext_q, ext_n;
	logic                   ext_big_q, ext_big_n;
	logic [3:0]             hdr_left_q, hdr_left_n;
	logic [31:0]            key_q, key_n;
	logic [1:0]             midx_q, midx_n;
	logic [LENGTH_BITS-1:0] frame_left_q, frame_left_n;
	logic [LENGTH_BITS-1:0] total_q, total_n;
	logic                   halted_q, halted_n;
	logic                   open_q, open_n;

	logic [WW-1:0]          max_w, cap_w;
	logic [LENGTH_BITS-1:0] lim, room, len_sel, ext_shift;
	logic                   big_sel, too_long;
	logic [7:0]             key_byte, plain;
	logic [2:0]             fin_status;

	assign max_w = WW'(max_len);
	assign cap_w = WW'({LENGTH_BITS{1'b1}});
	assign lim = LENGTH_BITS'((max_w > cap_w) ? cap_w : max_w);

	assign ext_shift = {ext_q[LENGTH_BITS-9:0], data_byte};
	assign len_sel = (phase_q == PH_HDR1) ? LENGTH_BITS'(data_byte[6:0]) : ext_shift;
	assign big_sel = (phase_q == PH_EXT) && (ext_big_q || (|ext_q[LENGTH_BITS-1 -: 8]));
	assign room = lim - total_q;
	assign too_long = big_sel || (total_q > lim) || (len_sel > room);

	assign key_byte = key_q[{~midx_q, 3'b000} +: 8];
	assign plain = data_byte ^ key_byte;
	assign fin_status = classify(first_op_q);

	always_comb begin
		phase_n      = phase_q;
		first_op_n   = first_op_q;
		fin_n        = fin_q;
		ext_n        = ext_q;
		ext_big_n    = ext_big_q;
		hdr_left_n   = hdr_left_q;
		key_n        = key_q;
		midx_n       = midx_q;
		frame_left_n = frame_left_q;
		total_n      = total_q;
		halted_n     = halted_q;
		open_n       = open_q;
		res_valid    = 1'b0;
		res          = '{payload_byte: 8'd0, payload_valid: 1'b0, message_end: 1'b0,
			status: ST_TEXT, message_opcode: first_op_q};

		if (step && !halted_q) begin
			case (phase_q)
				PH_HDR0: begin
					fin_n = data_byte[7];
					if (!open_q) begin
						first_op_n = data_byte[3:0];
						open_n = 1'b1;
					end
					phase_n = PH_HDR1;
				end
				PH_HDR1, PH_EXT: begin
					if (phase_q == PH_HDR1 && !data_byte[7]) begin
						res_valid = 1'b1;
						res.message_end = 1'b1;
						res.status = ST_UNMASKED;
						halted_n = 1'b1;
					end else if (phase_q == PH_HDR1 &&
							(data_byte[6:0] inside {LEN7_EXT16, LEN7_EXT64})) begin
						ext_n = '0;
						ext_big_n = 1'b0;
						hdr_left_n = (data_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_n = PH_EXT;
					end else if (phase_q == PH_EXT && hdr_left_q != 4'd1) begin
						ext_n = ext_shift;
						ext_big_n = big_sel;
						hdr_left_n = hdr_left_q - 4'd1;
					end else if (too_long) begin
						res_valid = 1'b1;
						res.message_end = 1'b1;
						res.status = ST_TOOLONG;
						halted_n = 1'b1;
					end else begin
						ext_n = ext_shift;
						hdr_left_n = KEY_BYTES;
						total_n = total_q + len_sel;
						frame_left_n = len_sel;
						key_n = '0;
						midx_n = 2'd0;
						phase_n = PH_MASK;
					end
				end
				PH_MASK: begin
					key_n = {key_q[23:0], data_byte};
					hdr_left_n = hdr_left_q - 4'd1;
					if (hdr_left_q == 4'd1) begin
						midx_n = 2'd0;
						if (frame_left_q != '0) begin
							phase_n = PH_PAYLOAD;
						end else if (fin_q) begin
							res_valid = 1'b1;
							res.message_end = 1'b1;
							res.status = fin_status;
							halted_n = (fin_status != ST_TEXT);
							open_n = 1'b0;
							total_n = '0;
							phase_n = PH_HDR0;
						end else begin
							phase_n = PH_HDR0;
						end
					end
				end
				PH_PAYLOAD: begin
					midx_n = midx_q + 2'd1;
					frame_left_n = frame_left_q - LENGTH_BITS'(1);
					res_valid = 1'b1;
					res.payload_byte = plain;
					res.payload_valid = 1'b1;
					if (frame_left_q == LENGTH_BITS'(1)) begin
						phase_n = PH_HDR0;
						if (fin_q) begin
							res.message_end = 1'b1;
							res.status = fin_status;
							halted_n = (fin_status != ST_TEXT);
							open_n = 1'b0;
							total_n = '0;
						end
					end
				end
				default: begin
					phase_n = PH_HDR0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			first_op_q   <= 4'd0;
			fin_q        <= 1'b0;
			ext_q        <= '0;
			ext_big_q    <= 1'b0;
			hdr_left_q   <= 4'd0;
			key_q        <= '0;
			midx_q       <= 2'd0;
			frame_left_q <= '0;
			total_q      <= '0;
			halted_q     <= 1'b0;
			open_q       <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			first_op_q   <= first_op_n;
			fin_q        <= fin_n;
			ext_q        <= ext_n;
			ext_big_q    <= ext_big_n;
			hdr_left_q   <= hdr_left_n;
			key_q        <= key_n;
			midx_q       <= midx_n;
			frame_left_q <= frame_left_n;
			total_q      <= total_n;
			halted_q     <= halted_n;
			open_q       <= open_n;
		end
	end

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (frame_left_q != '0))
		else $error("payload phase entered with no bytes left");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");
	a_halt_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!halted_q && halted_n) |-> (res_valid && res.message_end))
		else $error("halt without an ending result");

endmodule
